[rtl/core/dpr_pkg.sv]
// Shared constants, types and register indexes for the disparity reprojection block.
package dpr_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int DISP_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 3 * BYTE_W;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int Q_W     = 32;

    // Signed numerator: pixel term plus a 32-bit register term
    localparam int NUM_TOP = (COORD_BITS + FRAC_BITS > CFG_W - 1) ?
                             (COORD_BITS + FRAC_BITS) : (CFG_W - 1);
    localparam int NUM_W   = NUM_TOP + 2;
    localparam int MAG_W   = NUM_W - 1;
    // Signed divisor: 8-bit disparity times a 32-bit gain plus an offset
    localparam int DEN_W   = DISP_W + 1 + CFG_W;
    localparam int DMAG_W  = DEN_W - 1;
    // Dividend is mag << FRAC_BITS; its low Q_W bits feed the cells one per step
    localparam int SHIFT   = Q_W - FRAC_BITS;
    localparam int HI_W    = MAG_W - SHIFT;

    localparam int NUM_LANES = 3;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_Z    = 2;
    localparam int DIV_STEPS = Q_W;

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef logic [IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_OFFSET_X       = t_reg_idx'(0);
    localparam t_reg_idx REG_OFFSET_Y       = t_reg_idx'(1);
    localparam t_reg_idx REG_FOCAL_TERM     = t_reg_idx'(2);
    localparam t_reg_idx REG_DISPARITY_GAIN = t_reg_idx'(3);
    localparam t_reg_idx REG_DIVISOR_OFFSET = t_reg_idx'(4);

    typedef struct packed {
        logic signed [CFG_W-1:0] offset_x;
        logic signed [CFG_W-1:0] offset_y;
        logic signed [CFG_W-1:0] focal_term;
        logic signed [CFG_W-1:0] disparity_gain;
        logic signed [CFG_W-1:0] divisor_offset;
    } t_cfg;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [DISP_W-1:0] disparity;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } t_pix;

    typedef struct packed {
        logic [DMAG_W-1:0] rem;
        logic [Q_W-1:0]    acc;
        logic              neg;
        logic              ovf;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_LANES-1:0] lane;
        logic [DMAG_W-1:0]     den;
        logic                  wzero;
        logic [COLOR_W-1:0]    color;
    } t_cell;

    typedef struct packed {
        logic signed [Q_W-1:0] point_x;
        logic signed [Q_W-1:0] point_y;
        logic signed [Q_W-1:0] point_z;
        logic [COLOR_W-1:0]    packed_color;
        logic                  point_valid;
    } t_point;

endpackage

[rtl/core/dpr_if.sv]
// Channel interfaces: pixel input, point output and register write.
interface dpr_pix_if;
    import dpr_pkg::*;
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [DISP_W-1:0] disparity;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    modport source (output valid, column, row, disparity, blue, green, red, input ready);
    modport sink   (input valid, column, row, disparity, blue, green, red, output ready);
endinterface

interface dpr_pt_if;
    import dpr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] point_x;
    logic signed [Q_W-1:0] point_y;
    logic signed [Q_W-1:0] point_z;
    logic [COLOR_W-1:0]    packed_color;
    logic                  point_valid;
    modport source (output valid, point_x, point_y, point_z, packed_color, point_valid,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_z, packed_color, point_valid,
                    output ready);
endinterface

interface dpr_cfg_if;
    import dpr_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/dpr_front.sv]
// Front end: divisor, numerators, magnitudes and overflow check ahead of the divider cells.
module dpr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  dpr_pkg::t_pix i_pix,
    input  dpr_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output dpr_pkg::t_cell o_cell
);
    import dpr_pkg::*;

    // stage 1: divisor and signed numerators
    logic signed [DISP_W:0]     d_s;
    logic signed [DEN_W-1:0]    prod;
    logic [COORD_BITS-1:0]      col;
    logic [COORD_BITS-1:0]      row;
    logic signed [DEN_W-1:0]    n_s1_w;
    logic signed [NUM_W-1:0]    n_s1_num [NUM_LANES];
    logic                       n_s1_valid;
    logic signed [DEN_W-1:0]    r_s1_w;
    logic signed [NUM_W-1:0]    r_s1_num [NUM_LANES];
    logic [COLOR_W-1:0]         r_s1_color;
    logic                       r_s1_valid;

    always_comb begin
        d_s    = signed'({1'b0, i_pix.disparity});
        prod   = d_s * i_cfg.disparity_gain;
        n_s1_w = prod + DEN_W'(i_cfg.divisor_offset);
        col    = COORD_BITS'(i_pix.column);
        row    = COORD_BITS'(i_pix.row);
        n_s1_num[LANE_X] = NUM_W'(signed'({1'b0, col, {FRAC_BITS{1'b0}}}))
                         + NUM_W'(i_cfg.offset_x);
        n_s1_num[LANE_Y] = NUM_W'(signed'({1'b0, row, {FRAC_BITS{1'b0}}}))
                         + NUM_W'(i_cfg.offset_y);
        n_s1_num[LANE_Z] = NUM_W'(i_cfg.focal_term);
        // drop zero-disparity pixels here
        n_s1_valid = i_valid && (i_pix.disparity != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_w     <= n_s1_w;
            r_s1_num   <= n_s1_num;
            r_s1_color <= {i_pix.red, i_pix.green, i_pix.blue};
        end
    end

    // stage 2: magnitudes and signs
    logic [MAG_W-1:0]  n_s2_mag [NUM_LANES];
    logic [NUM_LANES-1:0] n_s2_neg;
    logic [DMAG_W-1:0] n_s2_den;
    logic [MAG_W-1:0]  r_s2_mag [NUM_LANES];
    logic [NUM_LANES-1:0] r_s2_neg;
    logic [DMAG_W-1:0] r_s2_den;
    logic              r_s2_wzero;
    logic [COLOR_W-1:0] r_s2_color;
    logic              r_s2_valid;

    always_comb begin
        n_s2_den = r_s1_w[DEN_W-1] ? DMAG_W'(-r_s1_w) : DMAG_W'(r_s1_w);
        for (int k = 0; k < NUM_LANES; k++) begin
            n_s2_mag[k] = r_s1_num[k][NUM_W-1] ? MAG_W'(-r_s1_num[k]) : MAG_W'(r_s1_num[k]);
            n_s2_neg[k] = r_s1_num[k][NUM_W-1] ^ r_s1_w[DEN_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_mag   <= n_s2_mag;
            r_s2_neg   <= n_s2_neg;
            r_s2_den   <= n_s2_den;
            r_s2_wzero <= (r_s1_w == '0);
            r_s2_color <= r_s1_color;
        end
    end

    // stage 3: split dividend; flag overflow where the high part is not below the divisor
    logic [HI_W-1:0]  hi [NUM_LANES];
    logic [SHIFT-1:0] lo [NUM_LANES];
    t_cell            n_s3_cell;
    t_cell            r_s3_cell;
    logic             r_s3_valid;

    always_comb begin
        n_s3_cell.den   = r_s2_den;
        n_s3_cell.wzero = r_s2_wzero;
        n_s3_cell.color = r_s2_color;
        for (int k = 0; k < NUM_LANES; k++) begin
            hi[k] = r_s2_mag[k][MAG_W-1:SHIFT];
            lo[k] = r_s2_mag[k][SHIFT-1:0];
            n_s3_cell.lane[k].rem = DMAG_W'(hi[k]);
            n_s3_cell.lane[k].acc = {lo[k], {FRAC_BITS{1'b0}}};
            n_s3_cell.lane[k].neg = r_s2_neg[k];
            // quotient reaches 2^Q_W exactly when the high part is not below the divisor
            n_s3_cell.lane[k].ovf = (DMAG_W'(hi[k]) >= r_s2_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_cell <= n_s3_cell;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_cell  = r_s3_cell;

endmodule

[rtl/core/dpr_div_cell.sv]
// One restoring division step for the three coordinate lanes sharing one divisor.
module dpr_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  dpr_pkg::t_cell i_cell,
    output logic           o_valid,
    output dpr_pkg::t_cell o_cell
);
    import dpr_pkg::*;

    logic [DMAG_W:0] trial [NUM_LANES];
    logic [DMAG_W:0] diff  [NUM_LANES];
    logic            take  [NUM_LANES];
    t_cell           n_cell;
    t_cell           r_cell;
    logic            r_valid;

    always_comb begin
        n_cell = i_cell;
        for (int k = 0; k < NUM_LANES; k++) begin
            // shift in the next dividend bit, subtract where it fits
            trial[k] = {i_cell.lane[k].rem, i_cell.lane[k].acc[Q_W-1]};
            diff[k]  = trial[k] - {1'b0, i_cell.den};
            take[k]  = (trial[k] >= {1'b0, i_cell.den});
            n_cell.lane[k].rem = take[k] ? diff[k][DMAG_W-1:0] : trial[k][DMAG_W-1:0];
            n_cell.lane[k].acc = {i_cell.lane[k].acc[Q_W-2:0], take[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    a_rem_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_cell.wzero && !i_cell.lane[LANE_X].ovf
        |-> i_cell.lane[LANE_X].rem < i_cell.den)
        else $error("x lane remainder not below divisor");
    a_rem_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_cell.wzero && !i_cell.lane[LANE_Y].ovf
        |-> i_cell.lane[LANE_Y].rem < i_cell.den)
        else $error("y lane remainder not below divisor");
    a_rem_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_cell.wzero && !i_cell.lane[LANE_Z].ovf
        |-> i_cell.lane[LANE_Z].rem < i_cell.den)
        else $error("z lane remainder not below divisor");

endmodule

[rtl/core/dpr_finish.sv]
// Sign and saturation of the quotients, then a two-entry output skid buffer.
module dpr_finish (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  dpr_pkg::t_cell i_cell,
    output logic           o_en,
    dpr_pt_if.source       o_pt
);
    import dpr_pkg::*;

    localparam logic [1:0] SKID_EMPTY = 2'd0;
    localparam logic [1:0] SKID_ONE   = 2'd1;
    localparam logic [1:0] SKID_FULL  = 2'd2;

    function automatic logic [Q_W-1:0] saturate(input logic [Q_W-1:0] q,
                                                input logic neg, input logic ovf);
        if (neg) begin
            if (ovf || (q > Q_MIN)) begin
                return Q_MIN;
            end
            return -q;
        end
        if (ovf || q[Q_W-1]) begin
            return Q_MAX;
        end
        return q;
    endfunction

    t_point     n_point;
    t_point     n_slot0;
    t_point     n_slot1;
    t_point     r_slot0;
    t_point     r_slot1;
    logic [1:0] n_count;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    always_comb begin
        n_point.point_valid  = !i_cell.wzero;
        n_point.packed_color = i_cell.color;
        if (i_cell.wzero) begin
            n_point.point_x = '0;
            n_point.point_y = '0;
            n_point.point_z = '0;
        end else begin
            n_point.point_x = signed'(saturate(i_cell.lane[LANE_X].acc,
                              i_cell.lane[LANE_X].neg, i_cell.lane[LANE_X].ovf));
            n_point.point_y = signed'(saturate(i_cell.lane[LANE_Y].acc,
                              i_cell.lane[LANE_Y].neg, i_cell.lane[LANE_Y].ovf));
            n_point.point_z = signed'(saturate(i_cell.lane[LANE_Z].acc,
                              i_cell.lane[LANE_Z].neg, i_cell.lane[LANE_Z].ovf));
        end
    end

    // advance the pipeline only while a slot is sure to be free
    assign o_en = (r_count != SKID_FULL);
    assign push = i_valid && o_en;
    assign pop  = (r_count != SKID_EMPTY) && o_pt.ready;

    always_comb begin
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_count = r_count;
        case ({push, pop})
            2'b10: begin
                if (r_count == SKID_EMPTY) begin
                    n_slot0 = n_point;
                end else begin
                    n_slot1 = n_point;
                end
                n_count = r_count + 2'd1;
            end
            2'b01: begin
                n_slot0 = r_slot1;
                n_count = r_count - 2'd1;
            end
            2'b11: begin
                n_slot0 = (r_count == SKID_ONE) ? n_point : r_slot1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= SKID_EMPTY;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_pt.valid        = (r_count != SKID_EMPTY);
    assign o_pt.point_x      = r_slot0.point_x;
    assign o_pt.point_y      = r_slot0.point_y;
    assign o_pt.point_z      = r_slot0.point_z;
    assign o_pt.packed_color = r_slot0.packed_color;
    assign o_pt.point_valid  = r_slot0.point_valid;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("skid count out of range");
    a_full_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == SKID_FULL) && pop |=> r_slot0 == $past(r_slot1))
        else $error("second skid entry lost on pop");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt.valid && !o_pt.point_valid
        |-> (o_pt.point_x == '0) && (o_pt.point_y == '0) && (o_pt.point_z == '0))
        else $error("point with zero divisor carries coordinates");

endmodule

[rtl/core/disparity_to_point_reprojection.sv]
// Top level: register file, front end, chain of divider cells and output buffer.
//
//  channel  | modport | handshake     | payload
//  ---------+---------+---------------+-----------------------------------------------
//  i_pix    | sink    | valid / ready | column, row, disparity, blue, green, red
//  o_pt     | source  | valid / ready | point_x, point_y, point_z, packed_color,
//           |         |               | point_valid
//  i_cfg    | sink    | valid / ready | index, data (ready is always high)
//
//  One pixel per cycle while the output buffer is not full; the path runs through 3 front
//  stages, one cell per quotient bit (32) and the output register.
//  Synchronous active-low reset clears the valid bits, the skid count and the config registers.
//  A stalled output stops the whole pipeline once both skid entries are in use; the
//  input stays ready while one result waits.
module disparity_to_point_reprojection (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dpr_pix_if.sink   i_pix,
    dpr_cfg_if.sink   i_cfg,
    dpr_pt_if.source  o_pt
);
    import dpr_pkg::*;

    t_cfg  r_cfg;
    t_pix  w_pix;
    logic  w_en;
    t_cell w_cell  [DIV_STEPS+1];
    logic  w_valid [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_OFFSET_X:       r_cfg.offset_x       <= i_cfg.data;
                REG_OFFSET_Y:       r_cfg.offset_y       <= i_cfg.data;
                REG_FOCAL_TERM:     r_cfg.focal_term     <= i_cfg.data;
                REG_DISPARITY_GAIN: r_cfg.disparity_gain <= i_cfg.data;
                REG_DIVISOR_OFFSET: r_cfg.divisor_offset <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = w_en;

    assign w_pix.column    = i_pix.column;
    assign w_pix.row       = i_pix.row;
    assign w_pix.disparity = i_pix.disparity;
    assign w_pix.blue      = i_pix.blue;
    assign w_pix.green     = i_pix.green;
    assign w_pix.red       = i_pix.red;

    dpr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pix.valid),
        .i_pix   (w_pix),
        .i_cfg   (r_cfg),
        .o_valid (w_valid[0]),
        .o_cell  (w_cell[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        dpr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_cell  (w_cell[g]),
            .o_valid (w_valid[g+1]),
            .o_cell  (w_cell[g+1])
        );
    end

    dpr_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[DIV_STEPS]),
        .i_cell  (w_cell[DIV_STEPS]),
        .o_en    (w_en),
        .o_pt    (o_pt)
    );

endmodule
